>>> rtl/bounding_volume_pair_test_defines.svh
// Assertion macros for the bounding volume pair test
`ifndef BOUNDING_VOLUME_PAIR_TEST_DEFINES_SVH
`define BOUNDING_VOLUME_PAIR_TEST_DEFINES_SVH
// implication checked at every clock, quiet during reset
`define BVPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define BVPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/bvpt_pkg.sv
//------------------------------------------------------------------------------
// bvpt_pkg
// Shared types and codes for the bounding volume pair test.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bvpt_pkg;
    localparam int COORD_BITS = 20;
    localparam int FRAC_BITS  = 10;
    localparam int VEC_W      = 60;
    localparam int SCL_W      = 20;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [1:0] KIND_BOX    = 2'd0;
    localparam logic [1:0] KIND_SPHERE = 2'd1;
    localparam logic [1:0] KIND_PLANE  = 2'd2;
    localparam logic [1:0] KIND_UNK    = 2'd3;

    typedef enum logic [2:0] {
        PK_NONE  = 3'd0,
        PK_BB    = 3'd1,
        PK_SB    = 3'd2,
        PK_PB    = 3'd3,
        PK_PS    = 3'd4,
        PK_SS    = 3'd5,
        PK_PP    = 3'd6
    } t_pair;
endpackage
`default_nettype wire

>>> rtl/bvpt_front.sv
//------------------------------------------------------------------------------
// bvpt_front
// Classifies a pair, orders the volumes (p kind <= q kind), packs the fields.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bvpt_front #(
    parameter int COORD_BITS = bvpt_pkg::COORD_BITS
) (
    input  wire logic [1:0]               i_a_kind,
    input  wire logic                     i_a_enabled,
    input  wire logic [bvpt_pkg::VEC_W-1:0] i_a_vec_one,
    input  wire logic [bvpt_pkg::VEC_W-1:0] i_a_vec_two,
    input  wire logic [bvpt_pkg::SCL_W-1:0] i_a_scalar,
    input  wire logic [1:0]               i_b_kind,
    input  wire logic                     i_b_enabled,
    input  wire logic [bvpt_pkg::VEC_W-1:0] i_b_vec_one,
    input  wire logic [bvpt_pkg::VEC_W-1:0] i_b_vec_two,
    input  wire logic [bvpt_pkg::SCL_W-1:0] i_b_scalar,
    output bvpt_pkg::t_pair               o_pair,
    output logic [7*COORD_BITS-1:0]       o_p,
    output logic [7*COORD_BITS-1:0]       o_q
);
    logic swap;
    logic [7*COORD_BITS-1:0] a_w, b_w;

    assign a_w = {i_a_scalar[COORD_BITS-1:0], i_a_vec_two[3*COORD_BITS-1:0],
                  i_a_vec_one[3*COORD_BITS-1:0]};
    assign b_w = {i_b_scalar[COORD_BITS-1:0], i_b_vec_two[3*COORD_BITS-1:0],
                  i_b_vec_one[3*COORD_BITS-1:0]};
    assign swap = i_a_kind > i_b_kind;
    assign o_p = swap ? b_w : a_w;
    assign o_q = swap ? a_w : b_w;

    always_comb begin
        logic [1:0] kp, kq;
        kp = swap ? i_b_kind : i_a_kind;
        kq = swap ? i_a_kind : i_b_kind;
        o_pair = bvpt_pkg::PK_NONE;
        if (i_a_enabled && i_b_enabled && i_a_kind != bvpt_pkg::KIND_UNK
            && i_b_kind != bvpt_pkg::KIND_UNK) begin
            case (kp)
                bvpt_pkg::KIND_BOX: begin
                    case (kq)
                        bvpt_pkg::KIND_BOX:    o_pair = bvpt_pkg::PK_BB;
                        bvpt_pkg::KIND_SPHERE: o_pair = bvpt_pkg::PK_SB;
                        default:               o_pair = bvpt_pkg::PK_PB;
                    endcase
                end
                bvpt_pkg::KIND_SPHERE: begin
                    o_pair = (kq == bvpt_pkg::KIND_SPHERE) ? bvpt_pkg::PK_SS
                                                           : bvpt_pkg::PK_PS;
                end
                default: o_pair = bvpt_pkg::PK_PP;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/bvpt_queue.sv
//------------------------------------------------------------------------------
// bvpt_queue
// Small FIFO between front and back with registered storage.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bvpt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = bvpt_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output logic [WIDTH-1:0]      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0] r_cnt;
    logic push, pop;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (pop) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/bvpt_back.sv
//------------------------------------------------------------------------------
// bvpt_back
// Three-stage datapath: differences, products, sums and compare.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bvpt_back #(
    parameter int COORD_BITS = bvpt_pkg::COORD_BITS,
    parameter int FRAC_BITS  = bvpt_pkg::FRAC_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire bvpt_pkg::t_pair        i_pair,
    input  wire logic [7*COORD_BITS-1:0] i_p,
    input  wire logic [7*COORD_BITS-1:0] i_q,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_hit,
    output logic [2:0]                  o_pair_kind
);
    localparam int DW = COORD_BITS + 2;
    localparam int PW = 2*DW + 2;
    localparam int SW = PW + 3;
    typedef logic signed [COORD_BITS-1:0] t_c;
    typedef logic signed [DW-1:0] t_d;
    typedef logic signed [PW-1:0] t_p;
    typedef logic signed [SW-1:0] t_s;

    logic adv;
    logic r_v1, r_v2, r_v3;
    bvpt_pkg::t_pair r_k1, r_k2, r_k3;
    logic r_h3;
    logic [2:0] r_bb1;
    t_d r_x1 [6];
    t_d r_y1 [6];
    t_d r_ss1;
    t_c r_s_p1, r_s_q1;
    t_p r_m2 [6];
    t_s r_e2;
    logic r_bb2, r_neg2;

    assign adv = !r_v3 || i_ready;
    assign o_ready = adv;
    assign o_valid = r_v3;
    assign o_hit = r_h3;
    assign o_pair_kind = r_k3;

    function automatic t_c fld(input logic [7*COORD_BITS-1:0] w, input int i);
        fld = t_c'(w[i*COORD_BITS +: COORD_BITS]);
    endfunction

    // stage 1: operand pairs for six multiplies per test
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_k1 <= i_pair;
            r_s_p1 <= fld(i_p, 6);
            r_s_q1 <= fld(i_q, 6);
            r_ss1 <= t_d'(fld(i_p, 6)) + t_d'(fld(i_q, 6));
            for (int i = 0; i < 3; i++) begin
                t_c pmn, pmx, qmn, qmx;
                t_d dl, xa, ya, xb, yb;
                pmn = fld(i_p, i);
                pmx = fld(i_p, i + 3);
                qmn = fld(i_q, i);
                qmx = fld(i_q, i + 3);
                dl = '0;
                xa = '0;
                ya = '0;
                xb = '0;
                yb = '0;
                r_bb1[i] <= (pmx > qmn) && (pmn < qmx);
                case (i_pair)
                    bvpt_pkg::PK_SB: begin
                        if (qmn < pmn) dl = t_d'(qmn) - t_d'(pmn);
                        else if (qmn > pmx) dl = t_d'(qmn) - t_d'(pmx);
                        else dl = '0;
                        xa = dl;
                        ya = dl;
                    end
                    bvpt_pkg::PK_SS: begin
                        dl = t_d'(pmn) - t_d'(qmn);
                        xa = dl;
                        ya = dl;
                    end
                    bvpt_pkg::PK_PS: begin
                        xa = t_d'(qmn);
                        ya = t_d'(pmn);
                    end
                    bvpt_pkg::PK_PB: begin
                        dl = t_d'(pmx) - t_d'(pmn);
                        xa = t_d'(qmn);
                        ya = t_d'(pmn) + t_d'(pmx);
                        xb = (dl < 0) ? -dl : dl;
                        yb = (qmn < 0) ? -t_d'(qmn) : t_d'(qmn);
                    end
                    default: begin
                        xa = '0;
                    end
                endcase
                r_x1[i] <= xa;
                r_y1[i] <= ya;
                r_x1[i+3] <= xb;
                r_y1[i+3] <= yb;
            end
        end
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (adv) r_v1 <= i_valid;
    end

    // stage 2: products, plus the right-hand term
    always_ff @(posedge i_clk) begin
        if (adv) begin
            t_d sr, ss;
            sr = t_d'(r_s_q1);
            ss = r_ss1;
            r_k2 <= r_k1;
            r_bb2 <= &r_bb1;
            r_neg2 <= r_ss1 < 0;
            for (int j = 0; j < 6; j++) r_m2[j] <= t_p'(r_x1[j]) * t_p'(r_y1[j]);
            case (r_k1)
                bvpt_pkg::PK_SB: r_e2 <= t_s'(sr * sr);
                bvpt_pkg::PK_SS: r_e2 <= t_s'(ss * ss);
                bvpt_pkg::PK_PS: r_e2 <= (t_s'(r_s_p1) + t_s'(r_s_q1)) <<< FRAC_BITS;
                bvpt_pkg::PK_PB: r_e2 <= (t_s'(r_s_q1) <<< (FRAC_BITS + 1));
                default:         r_e2 <= '0;
            endcase
        end
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
    end

    // stage 3: sums and compare
    always_ff @(posedge i_clk) begin
        if (adv) begin
            t_s a3, b3, ad;
            a3 = t_s'(r_m2[0]) + t_s'(r_m2[1]) + t_s'(r_m2[2]);
            b3 = t_s'(r_m2[3]) + t_s'(r_m2[4]) + t_s'(r_m2[5]);
            ad = a3 - r_e2;
            r_k3 <= r_k2;
            case (r_k2)
                bvpt_pkg::PK_BB: r_h3 <= r_bb2;
                bvpt_pkg::PK_SB: r_h3 <= (a3 <= r_e2);
                bvpt_pkg::PK_SS: r_h3 <= !r_neg2 && (a3 <= r_e2);
                bvpt_pkg::PK_PS: r_h3 <= (a3 <= r_e2);
                bvpt_pkg::PK_PB: r_h3 <= ((ad < 0) ? -ad : ad) <= b3;
                default:         r_h3 <= 1'b0;
            endcase
        end
        if (!i_rst_n) r_v3 <= 1'b0;
        else if (adv) r_v3 <= r_v2;
    end
endmodule
`default_nettype wire

>>> rtl/bounding_volume_pair_test.sv
//------------------------------------------------------------------------------
// bounding_volume_pair_test
// Box, sphere and plane pair intersection test.
//------------------------------------------------------------------------------
// Takes one pair per cycle while the queue has room. The front classifies the
// pair and orders the two volumes; a four-word queue decouples it from a
// three-stage back end (operand differences, six parallel products, sums and
// compare). Throughput is one word per cycle when the output is not stalled;
// a stalled output holds the back end and then fills the queue.
`timescale 1ns / 1ps
`default_nettype none
module bounding_volume_pair_test #(
    parameter int COORD_BITS = bvpt_pkg::COORD_BITS,
    parameter int FRAC_BITS  = bvpt_pkg::FRAC_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_a_kind,
    input  wire logic        i_a_enabled,
    input  wire logic [59:0] i_a_vec_one,
    input  wire logic [59:0] i_a_vec_two,
    input  wire logic [19:0] i_a_scalar,
    input  wire logic [1:0]  i_b_kind,
    input  wire logic        i_b_enabled,
    input  wire logic [59:0] i_b_vec_one,
    input  wire logic [59:0] i_b_vec_two,
    input  wire logic [19:0] i_b_scalar,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_hit,
    output logic [2:0]       o_pair_kind
);
    localparam int QW = 3 + 14*COORD_BITS;
    bvpt_pkg::t_pair f_pair;
    logic [7*COORD_BITS-1:0] f_p, f_q, b_p, b_q;
    logic [QW-1:0] q_out;
    logic q_valid, b_ready;

    bvpt_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_a_kind(i_a_kind), .i_a_enabled(i_a_enabled), .i_a_vec_one(i_a_vec_one),
        .i_a_vec_two(i_a_vec_two), .i_a_scalar(i_a_scalar),
        .i_b_kind(i_b_kind), .i_b_enabled(i_b_enabled), .i_b_vec_one(i_b_vec_one),
        .i_b_vec_two(i_b_vec_two), .i_b_scalar(i_b_scalar),
        .o_pair(f_pair), .o_p(f_p), .o_q(f_q)
    );

    bvpt_queue #(.WIDTH(QW), .DEPTH(bvpt_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_data({f_pair, f_p, f_q}),
        .o_valid(q_valid), .i_ready(b_ready), .o_data(q_out)
    );

    assign b_p = q_out[14*COORD_BITS-1:7*COORD_BITS];
    assign b_q = q_out[7*COORD_BITS-1:0];

    bvpt_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(b_ready),
        .i_pair(bvpt_pkg::t_pair'(q_out[QW-1 -: 3])), .i_p(b_p), .i_q(b_q),
        .o_valid(o_valid), .i_ready(i_ready), .o_hit(o_hit), .o_pair_kind(o_pair_kind)
    );
endmodule
`default_nettype wire

>>> rtl/bvpt_checker.sv
//------------------------------------------------------------------------------
// bvpt_checker
// Port-level checks for the pair test, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "bounding_volume_pair_test_defines.svh"
module bvpt_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_hit,
    input wire logic [2:0] o_pair_kind
);
    `BVPT_ASSERT_IMP(a_code_range, i_clk, i_rst_n, o_valid, o_pair_kind <= bvpt_pkg::PK_PP)
    `BVPT_ASSERT_IMP(a_none_no_hit, i_clk, i_rst_n, o_valid && o_pair_kind == bvpt_pkg::PK_NONE, !o_hit)
    `BVPT_ASSERT_IMP(a_pp_no_hit, i_clk, i_rst_n, o_valid && o_pair_kind == bvpt_pkg::PK_PP, !o_hit)
    `BVPT_ASSERT_NXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_hit) && $stable(o_pair_kind))
endmodule
bind bounding_volume_pair_test bvpt_checker u_bvpt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_hit(o_hit), .o_pair_kind(o_pair_kind)
);
`default_nettype wire
